### rtl/leg_inverse_kinematics_assert.svh
// Assertion macros shared by the leg inverse kinematics RTL.
`ifndef LEG_INVERSE_KINEMATICS_ASSERT_SVH
`define LEG_INVERSE_KINEMATICS_ASSERT_SVH
`ifndef SYNTH
`define LIK_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("leg_inverse_kinematics: property failed");
`define LIK_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("leg_inverse_kinematics: forbidden condition");
`else
`define LIK_ASSERT(lbl, clk, rst, prop)
`define LIK_ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

### rtl/lik_pkg.sv
// Types, constants and helpers for the leg inverse kinematics block.
package lik_pkg;

   localparam int LIK_COORD_W             = 16;
   localparam int LIK_LEN_W               = 13;
   localparam int LIK_GOAL_W              = 12;
   localparam int LIK_REACH_W             = 17;
   localparam int LIK_POSITION_BITS       = 12;
   localparam int LIK_ANGLE_FRACTION_BITS = 24;
   localparam int LIK_CORDIC_STAGES       = 32;
   localparam int LIK_CRD_W               = 34;
   localparam int LIK_ACC_W               = 34;
   localparam int LIK_SQRT_W              = 28;
   localparam int LIK_PRE_SHIFT           = 14;
   localparam logic [LIK_LEN_W-1:0] LIK_LEN_RESET = 13'd2880;

   // arctangent of 2^-i in turns, 32 fraction bits
   localparam logic [31:0] LIK_ATAN_TABLE [LIK_CORDIC_STAGES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
   };

   typedef struct packed {
      logic signed [LIK_COORD_W-1:0] x_pos;
      logic signed [LIK_COORD_W-1:0] y_pos;
      logic signed [LIK_COORD_W-1:0] z_pos;
   } lik_req_type;

   typedef struct packed {
      logic [LIK_GOAL_W-1:0] left_ankle_pitch_goal;
      logic [LIK_GOAL_W-1:0] left_hip_pitch_goal;
      logic [LIK_GOAL_W-1:0] right_ankle_pitch_goal;
      logic [LIK_GOAL_W-1:0] right_hip_pitch_goal;
      logic [LIK_GOAL_W-1:0] roll_goal;
      logic                  unreachable;
   } lik_rsp_type;

   typedef struct packed {
      logic signed [LIK_COORD_W-1:0] fx;
      logic signed [LIK_COORD_W-1:0] fy;
      logic signed [LIK_REACH_W-1:0] reach;
      logic                          beyond;
      logic                          at_hip;
   } lik_side_type;

   typedef struct packed {
      logic beyond;
      logic at_hip;
   } lik_flag_type;

   // wrap an angle into one turn and floor it to servo units
   function automatic logic [LIK_GOAL_W-1:0] lik_to_goal(
      input logic [LIK_ACC_W-1:0] angle, input int frac_bits, input int pos_bits);
      logic [LIK_GOAL_W-1:0] goal;
      int                    idx;
      goal = '0;
      for (int k = 0; k < LIK_GOAL_W; k++) begin
         idx = frac_bits - pos_bits + k;
         if (idx < frac_bits) begin
            goal[k] = angle[idx[5:0]];
         end
      end
      return goal;
   endfunction

endpackage

### rtl/lik_sqrt.sv
// Pipelined floor square root, one result digit per stage.
`include "leg_inverse_kinematics_assert.svh"
module lik_sqrt #(
   parameter int OUT_W = 28
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [2*OUT_W-1:0]   in_rad,
   output logic                 out_valid,
   output logic [OUT_W-1:0]     out_root
);
   localparam int IN_W = 2 * OUT_W;
   localparam int RW   = OUT_W + 3;

   logic [IN_W-1:0]  rad_ff  [OUT_W];
   logic [RW-1:0]    rem_ff  [OUT_W];
   logic [OUT_W-1:0] root_ff [OUT_W];
   logic             vld_ff  [OUT_W];

   genvar k;
   generate
      for (k = 0; k < OUT_W; k++) begin : g_stage
         logic [IN_W-1:0]  rad_p;
         logic [RW-1:0]    rem_p;
         logic [OUT_W-1:0] root_p;
         logic             vld_p;
         logic [RW-1:0]    rem_sh;
         logic [RW-1:0]    trial;
         logic             ge;
         logic [RW-1:0]    rem_in;
         logic [OUT_W-1:0] root_in;

         if (k == 0) begin : g_first
            assign rad_p  = in_rad;
            assign rem_p  = '0;
            assign root_p = '0;
            assign vld_p  = in_valid;
         end else begin : g_next
            assign rad_p  = rad_ff[k-1];
            assign rem_p  = rem_ff[k-1];
            assign root_p = root_ff[k-1];
            assign vld_p  = vld_ff[k-1];
         end

         // bring down the next digit pair and try the subtraction
         always_comb begin
            rem_sh  = {rem_p[RW-3:0], rad_p[IN_W-1-2*k -: 2]};
            trial   = {1'b0, root_p, 2'b01};
            ge      = (rem_sh >= trial);
            rem_in  = ge ? (rem_sh - trial) : rem_sh;
            root_in = {root_p[OUT_W-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else begin
               vld_ff[k] <= vld_p;
            end
            rad_ff[k]  <= rad_p;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   endgenerate

   assign out_valid = vld_ff[OUT_W-1];
   assign out_root  = root_ff[OUT_W-1];

   // remainder of a floor root never exceeds twice the root
   `LIK_ASSERT(a_sqrt_rem, clock, reset, out_valid |-> (rem_ff[OUT_W-1] <= {2'b00, out_root, 1'b0}))

endmodule

### rtl/lik_cordic.sv
// Pipelined CORDIC vectoring unit giving atan2 in turns.
`include "leg_inverse_kinematics_assert.svh"
module lik_cordic #(
   parameter int FRAC_BITS = 24
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   input  logic signed [lik_pkg::LIK_CRD_W-1:0]    in_num,
   input  logic signed [lik_pkg::LIK_CRD_W-1:0]    in_den,
   output logic                                    out_valid,
   output logic signed [lik_pkg::LIK_ACC_W-1:0]    out_angle
);
   import lik_pkg::*;

   localparam int N = LIK_CORDIC_STAGES;
   localparam logic signed [LIK_ACC_W-1:0] HALF_TURN = LIK_ACC_W'(64'h8000_0000);

   logic signed [LIK_CRD_W-1:0] vx_ff  [N+1];
   logic signed [LIK_CRD_W-1:0] vy_ff  [N+1];
   logic signed [LIK_ACC_W-1:0] acc_ff [N+1];
   logic                        vld_ff [N+1];

   logic                        neg;
   logic signed [LIK_CRD_W-1:0] vx_in0;
   logic signed [LIK_CRD_W-1:0] vy_in0;
   logic signed [LIK_ACC_W-1:0] acc_in0;

   // fold the left half plane onto the right one
   always_comb begin
      neg     = in_den[LIK_CRD_W-1];
      vx_in0  = neg ? -in_den : in_den;
      vy_in0  = neg ? -in_num : in_num;
      acc_in0 = '0;
      if (neg) begin
         acc_in0 = in_num[LIK_CRD_W-1] ? -HALF_TURN : HALF_TURN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      vx_ff[0]  <= vx_in0;
      vy_ff[0]  <= vy_in0;
      acc_ff[0] <= acc_in0;
   end

   genvar i;
   generate
      for (i = 0; i < N; i++) begin : g_stage
         logic signed [LIK_CRD_W-1:0] dx;
         logic signed [LIK_CRD_W-1:0] dy;
         logic signed [LIK_CRD_W-1:0] vx_in;
         logic signed [LIK_CRD_W-1:0] vy_in;
         logic signed [LIK_ACC_W-1:0] acc_in;
         logic signed [LIK_ACC_W-1:0] step;

         // rotate toward the x axis; freeze once y has reached zero
         always_comb begin
            dx     = vy_ff[i] >>> i;
            dy     = vx_ff[i] >>> i;
            step   = $signed({{(LIK_ACC_W-32){1'b0}}, LIK_ATAN_TABLE[i]});
            vx_in  = vx_ff[i];
            vy_in  = vy_ff[i];
            acc_in = acc_ff[i];
            if (vy_ff[i] != '0) begin
               if (!vy_ff[i][LIK_CRD_W-1]) begin
                  vx_in  = vx_ff[i] + dx;
                  vy_in  = vy_ff[i] - dy;
                  acc_in = acc_ff[i] + step;
               end else begin
                  vx_in  = vx_ff[i] - dx;
                  vy_in  = vy_ff[i] + dy;
                  acc_in = acc_ff[i] - step;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[i+1] <= 1'b0;
            end else begin
               vld_ff[i+1] <= vld_ff[i];
            end
            vx_ff[i+1]  <= vx_in;
            vy_ff[i+1]  <= vy_in;
            acc_ff[i+1] <= acc_in;
         end
      end
   endgenerate

   assign out_valid = vld_ff[N];
   assign out_angle = acc_ff[N] >>> (32 - FRAC_BITS);

   // x is still on the right half plane after the last stage
   `LIK_ASSERT_NEVER(a_cordic_x_neg, clock, reset, out_valid && vx_ff[N][LIK_CRD_W-1])

endmodule

### rtl/leg_inverse_kinematics.sv
// Top level of the two-link leg inverse kinematics pipeline.
// Takes one foot target per clock: busy stays low, and every target accepted
// with start gives one result word on rsp_data with rsp_strobe high, in
// order. Its path runs through input, product and sum registers, the 28-digit
// square root pipeline, the CORDIC fold register, the 32 CORDIC stages and
// the output register. The link length register is written through
// csr_*, which is always ready; write it only while no target is in flight.
`include "leg_inverse_kinematics_assert.svh"
module leg_inverse_kinematics #(
   parameter int POSITION_BITS       = lik_pkg::LIK_POSITION_BITS,
   parameter int ANGLE_FRACTION_BITS = lik_pkg::LIK_ANGLE_FRACTION_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  lik_pkg::lik_req_type             req_data,
   output logic                             rsp_strobe,
   output lik_pkg::lik_rsp_type             rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lik_pkg::LIK_LEN_W-1:0]    csr_data
);
   import lik_pkg::*;

   localparam int LAT = 5 + LIK_SQRT_W + LIK_CORDIC_STAGES;
   localparam logic [LIK_ACC_W-1:0] QUARTER = LIK_ACC_W'(1) << (ANGLE_FRACTION_BITS - 2);
   localparam logic [LIK_ACC_W-1:0] HALF    = LIK_ACC_W'(1) << (ANGLE_FRACTION_BITS - 1);

   // link length register
   logic [LIK_LEN_W-1:0] len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LIK_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         len_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   // stage 1: capture the target word
   logic                          s1_valid_ff;
   logic signed [LIK_COORD_W-1:0] s1_x_ff;
   logic signed [LIK_COORD_W-1:0] s1_y_ff;
   logic signed [LIK_COORD_W-1:0] s1_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      s1_x_ff <= req_data.x_pos;
      s1_y_ff <= req_data.y_pos;
      s1_z_ff <= req_data.z_pos;
   end

   // stage 2: reach and the squares
   logic signed [LIK_REACH_W-1:0] reach_in;
   logic signed [33:0]            rsq_full;
   logic signed [33:0]            xsq_full;
   logic [25:0]                   lsq_in;

   always_comb begin
      reach_in = $signed({3'b000, len_ff, 1'b0}) - $signed({s1_z_ff[LIK_COORD_W-1], s1_z_ff});
      rsq_full = 34'(reach_in) * 34'(reach_in);
      xsq_full = 34'(s1_x_ff) * 34'(s1_x_ff);
      lsq_in   = 26'(len_ff) * 26'(len_ff);
   end

   logic                          s2_valid_ff;
   logic signed [LIK_COORD_W-1:0] s2_x_ff;
   logic signed [LIK_COORD_W-1:0] s2_y_ff;
   logic signed [LIK_REACH_W-1:0] s2_reach_ff;
   logic [31:0]                   s2_rsq_ff;
   logic [31:0]                   s2_xsq_ff;
   logic [25:0]                   s2_lsq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_x_ff     <= s1_x_ff;
      s2_y_ff     <= s1_y_ff;
      s2_reach_ff <= reach_in;
      s2_rsq_ff   <= rsq_full[31:0];
      s2_xsq_ff   <= xsq_full[31:0];
      s2_lsq_ff   <= lsq_in;
   end

   // stage 3: distance, reach tests and root radicands
   logic [32:0]              dist_in;
   logic [27:0]              span_in;
   logic [27:0]              gap_in;
   logic                     beyond_in;
   logic                     at_hip_in;
   logic [2*LIK_SQRT_W-1:0]  adj_rad_in;
   logic [2*LIK_SQRT_W-1:0]  opp_rad_in;

   always_comb begin
      dist_in    = {1'b0, s2_rsq_ff} + {1'b0, s2_xsq_ff};
      span_in    = {s2_lsq_ff, 2'b00};
      beyond_in  = dist_in > {5'd0, span_in};
      at_hip_in  = (dist_in == '0);
      gap_in     = span_in - dist_in[27:0];
      adj_rad_in = beyond_in ? '0 : {dist_in[27:0], 28'd0};
      opp_rad_in = beyond_in ? '0 : {gap_in, 28'd0};
   end

   logic                    s3_valid_ff;
   logic [2*LIK_SQRT_W-1:0] s3_adj_ff;
   logic [2*LIK_SQRT_W-1:0] s3_opp_ff;
   lik_side_type            s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_adj_ff         <= adj_rad_in;
      s3_opp_ff         <= opp_rad_in;
      s3_side_ff.fx     <= s2_x_ff;
      s3_side_ff.fy     <= s2_y_ff;
      s3_side_ff.reach  <= s2_reach_ff;
      s3_side_ff.beyond <= beyond_in;
      s3_side_ff.at_hip <= at_hip_in;
   end

   // square roots for the bend angle
   logic                  sq_valid;
   logic [LIK_SQRT_W-1:0] adj_root;
   logic [LIK_SQRT_W-1:0] opp_root;

   lik_sqrt #(.OUT_W(LIK_SQRT_W)) u_sqrt_adj (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_rad    (s3_adj_ff),
      .out_valid (sq_valid),
      .out_root  (adj_root)
   );

   lik_sqrt #(.OUT_W(LIK_SQRT_W)) u_sqrt_opp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_rad    (s3_opp_ff),
      .out_valid (),
      .out_root  (opp_root)
   );

   // carry the coordinates alongside the roots
   lik_side_type side_dly_ff [LIK_SQRT_W];
   lik_side_type side_q;

   always_ff @(posedge clock) begin
      side_dly_ff[0] <= s3_side_ff;
      for (int j = 1; j < LIK_SQRT_W; j++) begin
         side_dly_ff[j] <= side_dly_ff[j-1];
      end
   end

   assign side_q = side_dly_ff[LIK_SQRT_W-1];

   // arctangent operands, coordinates scaled by 2^14
   logic signed [LIK_CRD_W-1:0]   x_sc;
   logic signed [LIK_CRD_W-1:0]   y_sc;
   logic signed [LIK_CRD_W-1:0]   h_sc;
   logic signed [LIK_CRD_W-1:0]   habs_sc;
   logic signed [LIK_REACH_W-1:0] reach_abs;
   logic signed [LIK_CRD_W-1:0]   adj_op;
   logic signed [LIK_CRD_W-1:0]   opp_op;

   always_comb begin
      reach_abs = side_q.reach[LIK_REACH_W-1] ? -side_q.reach : side_q.reach;
      x_sc      = LIK_CRD_W'($signed({side_q.fx, 14'd0}));
      y_sc      = LIK_CRD_W'($signed({side_q.fy, 14'd0}));
      h_sc      = LIK_CRD_W'($signed({side_q.reach, 14'd0}));
      habs_sc   = LIK_CRD_W'($signed({reach_abs, 14'd0}));
      adj_op    = $signed({{(LIK_CRD_W-LIK_SQRT_W){1'b0}}, adj_root});
      opp_op    = $signed({{(LIK_CRD_W-LIK_SQRT_W){1'b0}}, opp_root});
   end

   logic                        crd_valid;
   logic signed [LIK_ACC_W-1:0] lean_ang;
   logic signed [LIK_ACC_W-1:0] bend_ang;
   logic signed [LIK_ACC_W-1:0] slope_ang;
   logic signed [LIK_ACC_W-1:0] roll_ang;

   lik_cordic #(.FRAC_BITS(ANGLE_FRACTION_BITS)) u_crd_lean (
      .clock (clock), .reset (reset), .in_valid (sq_valid),
      .in_num (x_sc), .in_den (h_sc), .out_valid (), .out_angle (lean_ang)
   );

   lik_cordic #(.FRAC_BITS(ANGLE_FRACTION_BITS)) u_crd_bend (
      .clock (clock), .reset (reset), .in_valid (sq_valid),
      .in_num (opp_op), .in_den (adj_op), .out_valid (crd_valid), .out_angle (bend_ang)
   );

   lik_cordic #(.FRAC_BITS(ANGLE_FRACTION_BITS)) u_crd_slope (
      .clock (clock), .reset (reset), .in_valid (sq_valid),
      .in_num (habs_sc), .in_den (x_sc), .out_valid (), .out_angle (slope_ang)
   );

   lik_cordic #(.FRAC_BITS(ANGLE_FRACTION_BITS)) u_crd_roll (
      .clock (clock), .reset (reset), .in_valid (sq_valid),
      .in_num (y_sc), .in_den (h_sc), .out_valid (), .out_angle (roll_ang)
   );

   // carry the reach flags alongside the CORDIC stages
   lik_flag_type flag_dly_ff [LIK_CORDIC_STAGES+1];
   lik_flag_type flag_q;

   always_ff @(posedge clock) begin
      flag_dly_ff[0].beyond <= side_q.beyond;
      flag_dly_ff[0].at_hip <= side_q.at_hip;
      for (int j = 1; j <= LIK_CORDIC_STAGES; j++) begin
         flag_dly_ff[j] <= flag_dly_ff[j-1];
      end
   end

   assign flag_q = flag_dly_ff[LIK_CORDIC_STAGES];

   // combine the angles, apply offsets and convert to servo units
   logic [LIK_ACC_W-1:0] bend_v;
   logic [LIK_ACC_W-1:0] slope_v;
   logic [LIK_ACC_W-1:0] hip;
   logic [LIK_ACC_W-1:0] ankle;
   lik_rsp_type          rsp_in;

   always_comb begin
      bend_v  = flag_q.beyond ? '0 : bend_ang;
      slope_v = flag_q.at_hip ? QUARTER : slope_ang;
      hip     = lean_ang + bend_v;
      ankle   = slope_v + bend_v - QUARTER;
      rsp_in.left_ankle_pitch_goal  =
         lik_to_goal(ankle - HALF, ANGLE_FRACTION_BITS, POSITION_BITS);
      rsp_in.left_hip_pitch_goal    =
         lik_to_goal(-(hip + HALF), ANGLE_FRACTION_BITS, POSITION_BITS);
      rsp_in.right_ankle_pitch_goal =
         lik_to_goal(-(ankle - HALF), ANGLE_FRACTION_BITS, POSITION_BITS);
      rsp_in.right_hip_pitch_goal   =
         lik_to_goal(hip + HALF, ANGLE_FRACTION_BITS, POSITION_BITS);
      rsp_in.roll_goal              =
         lik_to_goal(HALF + roll_ang, ANGLE_FRACTION_BITS, POSITION_BITS);
      rsp_in.unreachable            = flag_q.beyond || flag_q.at_hip;
   end

   logic        rsp_valid_ff;
   lik_rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= crd_valid;
      end
      rsp_data_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // every result word traces back to an earlier start
   `LIK_ASSERT(a_rsp_origin, clock, reset, rsp_strobe |-> $past(start, LAT))
   // a target cannot be both out of reach and at the hip
   `LIK_ASSERT_NEVER(a_flags_excl, clock, reset, s3_valid_ff && s3_side_ff.beyond && s3_side_ff.at_hip)

endmodule
